// ===== sv/tcw_pkg.sv =====
// text console writer: shared constants, codes and the controller/datapath interface types
// no dependencies; the controller, datapath and top level refer to it by scoped names
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // widths
  localparam int CUR_W     = $clog2(CELLS + 1);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CODE_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 2 * COLOR_W + CODE_W;
  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 2;

  // cursor landmarks
  localparam logic [CUR_W-1:0] CUR_END      = CUR_W'(CELLS);
  localparam logic [CUR_W-1:0] CUR_LAST_ROW = CUR_W'(CELLS - COLUMNS);
  localparam logic [CUR_W-1:0] CUR_LAST     = CUR_W'(CELLS - 1);
  localparam logic [CUR_W-1:0] CUR_COLUMNS  = CUR_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST     = COL_W'(COLUMNS - 1);

  // character codes
  localparam logic [CODE_W-1:0] CODE_NEWLINE     = 8'd10;
  localparam logic [CODE_W-1:0] CODE_FIRST_PRINT = 8'd32;
  localparam logic [CODE_W-1:0] CODE_LAST_PRINT  = 8'd126;
  localparam logic [CODE_W-1:0] CODE_BLANK       = 8'd0;

  // item modes
  localparam logic MODE_CLEAR = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

  // reset colors
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  // commands from controller to datapath
  typedef struct packed {
    logic take;       // item transfer in, latch its code
    logic step;       // printable or newline without scroll
    logic ignore;     // ignored code, report unchanged cursor
    logic sweep_clr;  // sweep counter to zero
    logic sweep_inc;  // sweep counter up by one
    logic copy;       // move one cell up a row
    logic blank;      // blank one cell of the last row
    logic fill;       // blank one cell of the whole screen
    logic fill_done;  // clear finished, home the cursor
    logic finish;     // scroll finished, apply the pending code
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_print;
    logic is_newline;
    logic at_end;
    logic sweep_last;
    logic sweep_copy_end;
    logic out_valid;
  } status_t;

endpackage

// ===== sv/tcw_ram.sv =====
// generic single write port, single read port memory with registered read data
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tcw_ctrl.sv =====
// text console writer controller: sequences direct cursor updates, scroll and clear sweeps
// depends on tcw_pkg
module tcw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FILL   = 5'b00010,
    S_COPY   = 5'b00100,
    S_BLANK  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   out_drain;

  // the waiting result leaves at this edge
  assign out_drain = !out_stall;

  // accept only when idle and the result register is free or draining
  assign in_stall = !((state == S_IDLE) && (!status.out_valid || out_drain));

  assign take = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.take = 1'b1;
          if (status.is_clear) begin
            cmd.sweep_clr = 1'b1;
            state_next    = S_FILL;
          end else if (!status.is_print && !status.is_newline) begin
            cmd.ignore = 1'b1;
          end else if (status.at_end) begin
            cmd.sweep_clr = 1'b1;
            state_next    = S_COPY;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.sweep_last) begin
          cmd.fill_done = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.sweep_copy_end) begin
          state_next = S_BLANK;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_BLANK: begin
        cmd.blank = 1'b1;
        if (status.sweep_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a scroll copy always ends in the blanking of the last row
  a_copy_to_blank: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |=> (state == S_COPY || state == S_BLANK))
    else $error("copy sweep left without blanking the last row");

  // no item is taken during a sweep
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !take)
    else $error("item taken while a sweep is running");

endmodule

// ===== sv/tcw_datapath.sv =====
// text console writer datapath: cursor, colors, sweep counter, cell store and result register
// depends on tcw_pkg and tcw_ram
module tcw_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::status_t                 status,
  input  logic                             mode,
  input  logic [tcw_pkg::CODE_W-1:0]       char_code,
  input  logic                             cfg_valid,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [tcw_pkg::POS_W-1:0]        cursor_position,
  output logic                             scrolled,
  output logic                             accepted
);

  // registers
  logic [tcw_pkg::CUR_W-1:0]   cursor;
  logic [tcw_pkg::CUR_W-1:0]   cursor_next;
  logic [tcw_pkg::COL_W-1:0]   column;
  logic [tcw_pkg::COL_W-1:0]   column_next;
  logic [tcw_pkg::CUR_W-1:0]   sweep;
  logic [tcw_pkg::COLOR_W-1:0] fg_color;
  logic [tcw_pkg::COLOR_W-1:0] bg_color;
  logic                        pend_print;
  logic [tcw_pkg::CODE_W-1:0]  pend_code;

  // combinational
  logic                         in_print;
  logic                         in_newline;
  logic [tcw_pkg::CUR_W-1:0]    base;
  logic [tcw_pkg::COL_W-1:0]    base_col;
  logic                         base_print;
  logic                         update;
  logic                         out_load;
  logic                         ram_we;
  logic [tcw_pkg::ADDR_W-1:0]   ram_wr_addr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wr_data;
  logic                         ram_rd_en;
  logic [tcw_pkg::ADDR_W-1:0]   ram_rd_addr;
  logic [tcw_pkg::CELL_W-1:0]   ram_rd_data;
  logic [tcw_pkg::CELL_W-1:0]   blank_cell;
  logic [tcw_pkg::CUR_W-1:0]    sweep_prev;

  // item decode
  assign in_print   = (char_code >= tcw_pkg::CODE_FIRST_PRINT) &&
                      (char_code <= tcw_pkg::CODE_LAST_PRINT);
  assign in_newline = (char_code == tcw_pkg::CODE_NEWLINE);

  assign status.is_clear       = (mode == tcw_pkg::MODE_CLEAR);
  assign status.is_print       = in_print;
  assign status.is_newline     = in_newline;
  assign status.at_end         = (cursor == tcw_pkg::CUR_END);
  assign status.sweep_last     = (sweep == tcw_pkg::CUR_LAST);
  assign status.sweep_copy_end = (sweep == tcw_pkg::CUR_LAST_ROW);
  assign status.out_valid      = out_valid;

  assign blank_cell = {bg_color, fg_color, tcw_pkg::CODE_BLANK};
  assign sweep_prev = sweep - tcw_pkg::CUR_W'(1);

  // cursor update, directly or after a scroll from the last row start
  assign update     = cmd.step || cmd.finish;
  assign base       = cmd.finish ? tcw_pkg::CUR_LAST_ROW : cursor;
  assign base_col   = cmd.finish ? '0 : column;
  assign base_print = cmd.finish ? pend_print : in_print;

  always_comb begin
    cursor_next = cursor;
    column_next = column;
    if (update) begin
      if (base_print) begin
        cursor_next = base + tcw_pkg::CUR_W'(1);
        column_next = (base_col == tcw_pkg::COL_LAST) ? '0 : base_col + tcw_pkg::COL_W'(1);
      end else begin
        cursor_next = base + tcw_pkg::CUR_COLUMNS - tcw_pkg::CUR_W'(base_col);
        column_next = '0;
      end
    end else if (cmd.fill_done) begin
      cursor_next = '0;
      column_next = '0;
    end
  end

  // cell store write and read port selection
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = sweep[tcw_pkg::ADDR_W-1:0];
    ram_wr_data = blank_cell;
    ram_rd_en   = 1'b0;
    ram_rd_addr = tcw_pkg::ADDR_W'(sweep + tcw_pkg::CUR_COLUMNS);
    if (cmd.step && in_print) begin
      ram_we      = 1'b1;
      ram_wr_addr = cursor[tcw_pkg::ADDR_W-1:0];
      ram_wr_data = {bg_color, fg_color, char_code};
    end else if (cmd.finish && pend_print) begin
      ram_we      = 1'b1;
      ram_wr_addr = tcw_pkg::CUR_LAST_ROW[tcw_pkg::ADDR_W-1:0];
      ram_wr_data = {bg_color, fg_color, pend_code};
    end else if (cmd.copy) begin
      // read one row below, write the previous read in the following cycle
      ram_rd_en   = (sweep != tcw_pkg::CUR_LAST_ROW);
      ram_we      = (sweep != '0);
      ram_wr_addr = sweep_prev[tcw_pkg::ADDR_W-1:0];
      ram_wr_data = ram_rd_data;
    end else if (cmd.blank || cmd.fill) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_cells (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // cursor, column and color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      column   <= '0;
      fg_color <= tcw_pkg::FG_RESET;
      bg_color <= tcw_pkg::BG_RESET;
    end else begin
      cursor <= cursor_next;
      column <= column_next;
      if (cfg_valid && cfg_index == tcw_pkg::CFG_FG_COLOR) begin
        fg_color <= cfg_data;
      end
      if (cfg_valid && cfg_index == tcw_pkg::CFG_BG_COLOR) begin
        bg_color <= cfg_data;
      end
    end
  end

  // sweep counter and pending code of a scrolling item
  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + tcw_pkg::CUR_W'(1);
    end
    if (cmd.take) begin
      pend_print <= in_print;
      pend_code  <= char_code;
    end
  end

  // result register
  assign out_load = update || cmd.ignore || cmd.fill_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_position <= tcw_pkg::POS_W'(cursor_next);
      scrolled        <= cmd.finish;
      accepted        <= !cmd.ignore;
    end
  end

  // the cursor never runs past the end of the store
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= tcw_pkg::CUR_END)
    else $error("cursor beyond end of store");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("result overwritten before transfer");

endmodule

// ===== sv/text_console_writer_core.sv =====
// text console writer top level: 80x25 cell store with cursor, scroll and clear
// printable, newline, ignored codes: registered result, up to one per cycle unless stalled
// a scroll moves the lower rows up one row, then blanks the last row, one cell per cycle
// a clear writes a blank to every cell, one cell written per cycle
// reset: synchronous, clears cursor and column, fg color 15, bg color 0; store is not cleared
module text_console_writer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [tcw_pkg::CODE_W-1:0]       char_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcw_pkg::POS_W-1:0]        cursor_position,
  output logic                             scrolled,
  output logic                             accepted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (mode),
    .char_code       (char_code),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .cursor_position (cursor_position),
    .scrolled        (scrolled),
    .accepted        (accepted)
  );

endmodule
